[rtl/rse_pkg.sv]
// Shared types and constants for the RPN stack evaluator.
// No dependencies; used by every module under rtl/ except rse_checker.
package rse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_AW        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DATA_W      = 32;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DCNT_W      = $clog2(DIV_STEPS);

   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_SLASH = 8'h2F;
   localparam logic [7:0] SYM_EQUAL = 8'h3D;
   localparam logic [7:0] SYM_SPACE = 8'h20;
   localparam logic [7:0] SYM_TAB   = 8'h09;
   localparam logic [7:0] SYM_CR    = 8'h0D;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_OVF   = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;

   typedef enum logic [2:0] {
      OP_DIGIT,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_EQ,
      OP_SKIP,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
   } cmd_type;

endpackage

[rtl/rse_front.sv]
// Front end: takes symbol beats and classifies them into commands.
// Depends on rse_pkg; feeds rse_queue.
module rse_front (
   input  logic             req_valid,
   input  logic [7:0]       req_symbol,
   output logic             req_stall,
   input  logic             q_full,
   output logic             push,
   output rse_pkg::cmd_type push_cmd
);

   logic [7:0] offset;

   assign offset = req_symbol - rse_pkg::SYM_ZERO;

   always_comb begin
      push_cmd.digit = offset[3:0];
      unique case (req_symbol) inside
         [rse_pkg::SYM_ZERO:rse_pkg::SYM_NINE]: push_cmd.op = rse_pkg::OP_DIGIT;
         rse_pkg::SYM_PLUS:                     push_cmd.op = rse_pkg::OP_ADD;
         rse_pkg::SYM_MINUS:                    push_cmd.op = rse_pkg::OP_SUB;
         rse_pkg::SYM_STAR:                     push_cmd.op = rse_pkg::OP_MUL;
         rse_pkg::SYM_SLASH:                    push_cmd.op = rse_pkg::OP_DIV;
         rse_pkg::SYM_EQUAL:                    push_cmd.op = rse_pkg::OP_EQ;
         [rse_pkg::SYM_TAB:rse_pkg::SYM_CR],
         rse_pkg::SYM_SPACE:                    push_cmd.op = rse_pkg::OP_SKIP;
         default:                               push_cmd.op = rse_pkg::OP_BAD;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

endmodule

[rtl/rse_queue.sv]
// Small command FIFO between front end and execution back end.
// Depends on rse_pkg.
module rse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rse_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output rse_pkg::cmd_type pop_cmd
);

   localparam logic [rse_pkg::Q_AW-1:0] Q_LAST = rse_pkg::Q_AW'(rse_pkg::QUEUE_DEPTH - 1);
   localparam logic [rse_pkg::QCNT_W-1:0] Q_FULL =
      rse_pkg::QCNT_W'(rse_pkg::QUEUE_DEPTH);

   rse_pkg::cmd_type              entry_ff [rse_pkg::QUEUE_DEPTH];
   logic [rse_pkg::Q_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rse_pkg::Q_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rse_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push, do_pop;

   assign full      = (count_ff == Q_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/rse_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rse_pkg; used by rse_back.
module rse_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rse_pkg::DATA_W-1:0] dividend,
   input  logic [rse_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [rse_pkg::DATA_W-1:0] quotient
);

   localparam int W = rse_pkg::DATA_W;
   localparam logic [rse_pkg::DCNT_W-1:0] CNT_LAST = rse_pkg::DCNT_W'(rse_pkg::DIV_STEPS - 1);

   logic                      busy_ff, done_ff, neg_ff;
   logic [rse_pkg::DCNT_W-1:0] cnt_ff;
   logic [W-1:0]              rem_ff, quo_ff, den_ff;
   logic [W:0]                shifted, diff;

   assign shifted  = {rem_ff, quo_ff[W-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = neg_ff ? ('0 - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[W-1] ^ divisor[W-1];
         quo_ff <= dividend[W-1] ? ('0 - dividend) : dividend;
         den_ff <= divisor[W-1] ? ('0 - divisor) : divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_ff <= diff[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end

endmodule

[rtl/rse_back.sv]
// Back end: operand stack memory, ALU sequencer and result register.
// Depends on rse_pkg and rse_div; pops commands from rse_queue.
module rse_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  rse_pkg::cmd_type           q_cmd,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rse_pkg::DATA_W-1:0] rsp_value,
   output logic                       rsp_value_valid,
   output logic [2:0]                 rsp_status
);

   localparam int W  = rse_pkg::DATA_W;
   localparam int SW = rse_pkg::SP_W;
   localparam int AW = rse_pkg::ADDR_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_WB,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [SW-1:0]      sp_ff, sp_in;
   rse_pkg::op_type    op_ff, op_in;
   logic [W-1:0]       res_ff, res_in;
   logic [2:0]         st_ff, st_in;
   logic               vv_ff, vv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]       rsp_value_ff;
   logic               rsp_value_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic               load;

   logic [W-1:0]       stack_mem [rse_pkg::STACK_DEPTH];
   logic [W-1:0]       rhs_ff, lhs_ff;
   logic [SW-1:0]      sp_m1, sp_m2;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [W-1:0]       mem_wdata;

   logic               div_start, div_done;
   logic [W-1:0]       div_quot;

   assign sp_m1 = sp_ff - SW'(1);
   assign sp_m2 = sp_ff - SW'(2);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rhs_ff <= stack_mem[sp_m1[AW-1:0]];
      lhs_ff <= stack_mem[sp_m2[AW-1:0]];
   end

   rse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lhs_ff),
      .divisor  (rhs_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      op_in     = op_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      vv_in     = vv_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = sp_ff[AW-1:0];
      mem_wdata = {{(W-4){1'b0}}, q_cmd.digit};
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_cmd.op;
               res_in   = '0;
               vv_in    = 1'b0;
               st_in    = rse_pkg::ST_OK;
               state_in = S_DONE;
               case (q_cmd.op)
                  rse_pkg::OP_DIGIT: begin
                     if (sp_ff == rse_pkg::SP_FULL) begin
                        st_in = rse_pkg::ST_OVF;
                        sp_in = '0;
                     end else begin
                        mem_we = 1'b1;
                        sp_in  = sp_ff + SW'(1);
                     end
                  end
                  rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV: begin
                     if (sp_ff < SW'(2)) begin
                        st_in = rse_pkg::ST_UNDER;
                        sp_in = '0;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  rse_pkg::OP_EQ: begin
                     if (sp_ff == '0) begin
                        st_in = rse_pkg::ST_UNDER;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  rse_pkg::OP_BAD: begin
                     st_in = rse_pkg::ST_BAD;
                     sp_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_WB;
            case (op_ff)
               rse_pkg::OP_ADD: res_in = lhs_ff + rhs_ff;
               rse_pkg::OP_SUB: res_in = lhs_ff - rhs_ff;
               rse_pkg::OP_MUL: res_in = lhs_ff * rhs_ff;
               rse_pkg::OP_DIV: begin
                  if (rhs_ff == '0) begin
                     st_in    = rse_pkg::ST_DIV0;
                     sp_in    = '0;
                     state_in = S_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               rse_pkg::OP_EQ: begin
                  res_in   = rhs_ff;
                  vv_in    = 1'b1;
                  sp_in    = sp_m1;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = S_WB;
            end
         end
         S_WB: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m2[AW-1:0];
            mem_wdata = res_ff;
            sp_in     = sp_m1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
      st_ff  <= st_in;
      vv_ff  <= vv_in;
      if (load) begin
         rsp_value_ff       <= vv_ff ? res_ff : '0;
         rsp_value_valid_ff <= vv_ff;
         rsp_status_ff      <= st_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_value_valid = rsp_value_valid_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[rtl/rpn_stack_evaluator.sv]
// Top level of the RPN stack evaluator: front end, command queue, back end.
// Depends on rse_pkg, rse_front, rse_queue, rse_back (which holds rse_div).
//
// Usage:
//   req channel: one ASCII character per beat on req_symbol (req_valid/req_stall).
//   rsp channel: exactly one result beat per request beat, in order, carrying
//   rsp_value, rsp_value_valid (set for '=' that popped a value) and rsp_status.
//   Steps: a digit, whitespace, rejected character or underflow goes straight
//   to the result; '+' '-' '*' read operands, compute and write back; '=' pops;
//   '/' also runs the 32-step shift-subtract divider unless dividing by zero.
//   The back end takes a new command only after its result beat is loaded.
//   A two-entry command queue lets the front accept beats while the back end
//   works; req_stall rises only when that queue is full.
//   Reset (synchronous) empties the stack and the queue and drops any pending
//   result. Stack memory contents are not cleared; only entries below the
//   stack pointer are ever used.
//   When the receiver stalls, the result beat holds and the back end waits
//   with its next result; the queue keeps accepting until full.
module rpn_stack_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_value_valid,
   output logic [2:0]         rsp_status
);

   logic             push, q_full, q_valid, q_pop;
   rse_pkg::cmd_type push_cmd, q_cmd;
   logic [31:0]      value_raw;

   rse_front u_front (
      .req_valid  (req_valid),
      .req_symbol (req_symbol),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   rse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (value_raw),
      .rsp_value_valid (rsp_value_valid),
      .rsp_status      (rsp_status)
   );

   assign rsp_value = $signed(value_raw);

endmodule

[rtl/rse_checker.sv]
// Port-level checks for rpn_stack_evaluator, attached by bind.
// Depends only on the top level's ports.
module rse_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic               rsp_value_valid,
   input logic [2:0]         rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_status) && $stable(rsp_value_valid))
      else $error("rsp beat changed while stalled");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_valid |-> rsp_status == 3'd0)
      else $error("value reported with error status");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_value == 32'sd0)
      else $error("nonzero value without value_valid");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd4)
      else $error("status code out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);
